// File: hw/rtl/toi_pkg.sv
// ----------------------------------------------------------------------------
// toi_pkg
// Shared constants, widths, status codes and item types of the track
// observation insert block.
// ----------------------------------------------------------------------------
package toi_pkg;

  // sizing of the stores
  localparam int NUM_CAMERAS   = 64;
  localparam int MAX_FEATURES  = 4096;
  localparam int NUM_TRACKS    = 4096;
  localparam int MAX_PER_TRACK = 16;

  // fixed field widths of the items
  localparam int CAMERA_W      = 6;
  localparam int FEATURE_W     = 12;
  localparam int COORD_W       = 24;
  localparam int TRACK_W       = 12;
  localparam int STATUS_W      = 3;
  localparam int TRACK_COUNT_W = 5;

  // derived index widths
  localparam int CAM_IDX_W  = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  localparam int FEAT_IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int TRK_IDX_W  = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int SLOT_W     = (MAX_PER_TRACK > 1) ? $clog2(MAX_PER_TRACK) : 1;
  localparam int COUNT_W    = $clog2(MAX_PER_TRACK + 1);

  // observation store: one word per slot, {camera, feature, x, y}
  localparam int ENTRY_ADDR_W = TRK_IDX_W + SLOT_W;
  localparam int ENTRY_W      = CAMERA_W + FEATURE_W + 2 * COORD_W;

  // clearing pass covers both the count table and the feature map rows
  localparam int CLR_DEPTH = (NUM_TRACKS > MAX_FEATURES) ? NUM_TRACKS : MAX_FEATURES;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_MAPPED    = 3'd4,
    ST_FULL      = 3'd5
  } toi_status_t;

  // input item
  typedef struct packed {
    logic [CAMERA_W-1:0]         camera;
    logic [FEATURE_W-1:0]        feature;
    logic signed [COORD_W-1:0]   x_coord;
    logic signed [COORD_W-1:0]   y_coord;
    logic [TRACK_W-1:0]          track;
  } toi_in_t;

  // result item
  typedef struct packed {
    toi_status_t                 status;
    logic [TRACK_COUNT_W-1:0]    track_count;
  } toi_out_t;

  // observation store access
  typedef struct packed {
    logic                        rd;
    logic [ENTRY_ADDR_W-1:0]     raddr;
    logic                        wr;
    logic [ENTRY_ADDR_W-1:0]     waddr;
    logic [ENTRY_W-1:0]          wdata;
  } toi_ent_req_t;

  // track table access (counts and feature map)
  typedef struct packed {
    logic                        rd;
    logic                        wr;
    logic [TRK_IDX_W-1:0]        trk;
    logic [FEAT_IDX_W-1:0]       feat;
    logic [CAM_IDX_W-1:0]        cam;
    logic [COUNT_W-1:0]          count_wdata;
  } toi_tbl_req_t;

  typedef struct packed {
    logic                        clear_done;
    logic [COUNT_W-1:0]          count;
    logic                        map_hit;
  } toi_tbl_rsp_t;

endpackage

// File: hw/rtl/toi_entry_store.sv
// ----------------------------------------------------------------------------
// toi_entry_store
// Observation slots of all tracks: one write and one registered read port.
// ----------------------------------------------------------------------------
module toi_entry_store (
  input  logic                               clk,
  input  toi_pkg::toi_ent_req_t              req,
  output logic [toi_pkg::ENTRY_W-1:0]        rdata
);

  localparam int Depth = 2 ** toi_pkg::ENTRY_ADDR_W;

  logic [toi_pkg::ENTRY_W-1:0] mem [Depth];
  logic [toi_pkg::ENTRY_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/toi_track_table.sv
// ----------------------------------------------------------------------------
// toi_track_table
// Per-track observation counts and the feature map, one row of camera
// valid bits per feature. Clears both after reset, one row a cycle.
// ----------------------------------------------------------------------------
module toi_track_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  toi_pkg::toi_tbl_req_t  req,
  output toi_pkg::toi_tbl_rsp_t  rsp
);

  localparam int NumTracks = toi_pkg::NUM_TRACKS;
  localparam int NumFeat   = toi_pkg::MAX_FEATURES;
  localparam int NumCam    = toi_pkg::NUM_CAMERAS;
  localparam int CntW      = toi_pkg::COUNT_W;
  localparam int ClrW      = toi_pkg::CLR_W;
  localparam int TrkW      = toi_pkg::TRK_IDX_W;
  localparam int FeatW     = toi_pkg::FEAT_IDX_W;

  logic [CntW-1:0]   count_mem [NumTracks];
  logic [NumCam-1:0] map_mem   [NumFeat];

  logic [ClrW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic              clr_done_r, clr_done_nxt;
  logic [CntW-1:0]   count_rd_r;
  logic [NumCam-1:0] row_rd_r;
  logic [toi_pkg::CAM_IDX_W-1:0] cam_rd_r;
  logic [NumCam-1:0] row_set;
  logic              clr_cnt_hit;
  logic              clr_map_hit;

  // clearing pass sequencing
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_done_nxt = clr_done_r;
    if (!clr_done_r) begin
      if (clr_cnt_r == ClrW'(toi_pkg::CLR_DEPTH - 1)) begin
        clr_done_nxt = 1'b1;
      end else begin
        clr_cnt_nxt = ClrW'(clr_cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_done_r <= clr_done_nxt;
    end
  end

  assign clr_cnt_hit = !clr_done_r && (32'(clr_cnt_r) < 32'(NumTracks));
  assign clr_map_hit = !clr_done_r && (32'(clr_cnt_r) < 32'(NumFeat));

  // map row with the camera of the pending item set
  always_comb begin
    row_set           = row_rd_r;
    row_set[cam_rd_r] = 1'b1;
  end

  // count table: clear or write back
  always_ff @(posedge clk) begin
    if (clr_cnt_hit) begin
      count_mem[TrkW'(clr_cnt_r)] <= '0;
    end else if (req.wr) begin
      count_mem[req.trk] <= req.count_wdata;
    end
  end

  // feature map: clear or set the camera bit
  always_ff @(posedge clk) begin
    if (clr_map_hit) begin
      map_mem[FeatW'(clr_cnt_r)] <= '0;
    end else if (req.wr) begin
      map_mem[req.feat] <= row_set;
    end
  end

  // registered reads, held until the next lookup
  always_ff @(posedge clk) begin
    if (req.rd) begin
      count_rd_r <= count_mem[req.trk];
      row_rd_r   <= map_mem[req.feat];
      cam_rd_r   <= req.cam;
    end
  end

  assign rsp.clear_done = clr_done_r;
  assign rsp.count      = count_rd_r;
  assign rsp.map_hit    = row_rd_r[cam_rd_r];

endmodule

// File: hw/rtl/track_observation_insert.sv
// ----------------------------------------------------------------------------
// track_observation_insert
// Adds one camera observation to a point track after checking the track's
// stored observations and the feature-to-track map.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the count table and the
// feature map, one row a cycle over max(NUM_TRACKS, MAX_FEATURES) rows
// (4096 here), and holds busy high meanwhile. An item is taken when start
// is high and busy is low. Busy stays high until its result is decided, so
// no further item is taken before; the slot scan over the n observations
// already in its track reads the observation memory through its single
// read port, one slot a cycle. Items whose camera, feature or track index
// is out of range skip the lookup and answer in the next cycle. The
// result is shown for exactly one cycle with out_valid high and cannot be
// stalled; busy is already low during that cycle.
module track_observation_insert (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  toi_pkg::toi_in_t  in_item,
  output logic              out_valid,
  output toi_pkg::toi_out_t out_item
);

  localparam int CntW    = toi_pkg::COUNT_W;
  localparam int SlotW   = toi_pkg::SLOT_W;
  localparam int TrkW    = toi_pkg::TRK_IDX_W;
  localparam int FeatW   = toi_pkg::FEAT_IDX_W;
  localparam int CamW    = toi_pkg::CAM_IDX_W;
  localparam int OutCntW = toi_pkg::TRACK_COUNT_W;
  localparam int MaxPer  = toi_pkg::MAX_PER_TRACK;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  toi_pkg::toi_in_t    item_r, item_nxt;
  logic [CntW-1:0]     n_r, n_nxt;
  logic [CntW-1:0]     idx_r, idx_nxt;
  logic [1:0]          hits_r, hits_nxt;
  logic                differ_r, differ_nxt;
  logic                out_valid_r, out_valid_nxt;
  toi_pkg::toi_out_t   out_item_r, out_item_nxt;

  toi_pkg::toi_ent_req_t ent_req;
  logic [toi_pkg::ENTRY_W-1:0] ent_rdata;
  toi_pkg::toi_tbl_req_t tbl_req;
  toi_pkg::toi_tbl_rsp_t tbl_rsp;

  logic                accept;
  logic                in_range;
  logic [CntW-1:0]     n_clamp;
  logic [toi_pkg::ENTRY_W-1:0] item_word;
  logic                ent_cam_hit;
  logic [TrkW-1:0]     trk_idx;

  // storage
  toi_entry_store u_entry_store (
    .clk   (clk),
    .req   (ent_req),
    .rdata (ent_rdata)
  );

  toi_track_table u_track_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // index range check of a new item
  assign in_range = (32'(in_item.camera)  < 32'(toi_pkg::NUM_CAMERAS)) &&
                    (32'(in_item.feature) < 32'(toi_pkg::MAX_FEATURES)) &&
                    (32'(in_item.track)   < 32'(toi_pkg::NUM_TRACKS));

  // stored count, capped at the slot bound
  assign n_clamp = (32'(tbl_rsp.count) > 32'(MaxPer)) ? CntW'(MaxPer) : tbl_rsp.count;

  // slot word of the pending item and camera compare of the slot read
  assign item_word   = {item_r.camera, item_r.feature, item_r.x_coord, item_r.y_coord};
  assign ent_cam_hit = (ent_rdata[toi_pkg::ENTRY_W-1 -: toi_pkg::CAMERA_W] == item_r.camera);
  assign trk_idx     = TrkW'(item_r.track);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    hits_nxt      = hits_r;
    differ_nxt    = differ_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    ent_req       = '0;
    ent_req.raddr = {trk_idx, SlotW'(idx_r)};
    ent_req.waddr = {trk_idx, SlotW'(n_r)};
    ent_req.wdata = item_word;

    tbl_req             = '0;
    tbl_req.trk         = trk_idx;
    tbl_req.feat        = FeatW'(item_r.feature);
    tbl_req.cam         = CamW'(item_r.camera);
    tbl_req.count_wdata = CntW'(n_r + 1'b1);

    unique case (state_r)
      S_CLEAR: begin
        if (tbl_rsp.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        tbl_req.trk  = TrkW'(in_item.track);
        tbl_req.feat = FeatW'(in_item.feature);
        tbl_req.cam  = CamW'(in_item.camera);
        if (accept) begin
          item_nxt = in_item;
          if (in_range) begin
            tbl_req.rd = 1'b1;
            state_nxt  = S_LOOKUP;
          end else begin
            out_valid_nxt            = 1'b1;
            out_item_nxt.status      = toi_pkg::ST_FULL;
            out_item_nxt.track_count = '0;
          end
        end
      end
      S_LOOKUP: begin
        n_nxt      = n_clamp;
        hits_nxt   = '0;
        differ_nxt = 1'b0;
        if (n_clamp == '0) begin
          idx_nxt   = '0;
          state_nxt = S_DECIDE;
        end else begin
          ent_req.rd    = 1'b1;
          ent_req.raddr = {trk_idx, SlotW'(0)};
          idx_nxt       = CntW'(1);
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // slot idx_r - 1 is on the read data
        if (ent_cam_hit) begin
          hits_nxt = (hits_r == 2'd2) ? 2'd2 : 2'(hits_r + 1'b1);
          if (ent_rdata != item_word) begin
            differ_nxt = 1'b1;
          end
        end
        if (idx_r < n_r) begin
          ent_req.rd = 1'b1;
          idx_nxt    = CntW'(idx_r + 1'b1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.track_count = OutCntW'(n_r);
        if (hits_r != '0) begin
          if (differ_r) begin
            out_item_nxt.status = toi_pkg::ST_CONFLICT;
          end else if (hits_r == 2'd2) begin
            out_item_nxt.status = toi_pkg::ST_DUPLICATE;
          end else begin
            out_item_nxt.status = toi_pkg::ST_PRESENT;
          end
        end else if (tbl_rsp.map_hit) begin
          out_item_nxt.status = toi_pkg::ST_MAPPED;
        end else if (32'(n_r) >= 32'(MaxPer)) begin
          out_item_nxt.status = toi_pkg::ST_FULL;
        end else begin
          // append the observation and claim the feature
          ent_req.wr               = 1'b1;
          tbl_req.wr               = 1'b1;
          out_item_nxt.status      = toi_pkg::ST_ADDED;
          out_item_nxt.track_count = OutCntW'(n_r + 1'b1);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    hits_r     <= hits_nxt;
    differ_r   <= differ_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // every accepted item either starts the lookup or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  // the scan never reads past the stored count
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= n_r))
    else $error("slot scan beyond track count");

  // state is only written while deciding
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_req.wr || tbl_req.wr) |-> (state_r == S_DECIDE && ent_req.wr && tbl_req.wr))
    else $error("store written outside decision");

  // an added item leaves a non-empty track
  a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == toi_pkg::ST_ADDED) |-> (out_item.track_count != '0))
    else $error("added item with empty track");
`endif

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// track_observation_insert testbench
// Sends observation items through the start/busy handshake in bursts with
// random gaps. Each accepted item runs through a local predictor that keeps
// its own track counts, observation slots and feature map. Every result
// strobe is checked against the oldest prediction. A duplicate camera in
// one track cannot be built through inserts, since a camera is only
// appended to a track that has no entry for it yet.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_TOTAL  = toi_pkg::NUM_TRACKS * toi_pkg::MAX_PER_TRACK;
  localparam int MAP_TOTAL   = toi_pkg::NUM_CAMERAS * toi_pkg::MAX_FEATURES;
  localparam int IDENT_W     = toi_pkg::CAMERA_W + toi_pkg::FEATURE_W;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  toi_pkg::toi_in_t  in_item = '0;
  logic              out_valid;
  toi_pkg::toi_out_t out_item;

  // predictor state
  bit [4:0]                     track_fill [toi_pkg::NUM_TRACKS];
  bit [IDENT_W-1:0]             slot_ident [SLOT_TOTAL];
  bit [2*toi_pkg::COORD_W-1:0]  slot_coords [SLOT_TOTAL];
  bit                           feature_taken [MAP_TOTAL];

  toi_pkg::toi_out_t expected_results [$];
  toi_pkg::toi_in_t  recent_obs [$];
  int                mismatch_count = 0;
  int                burst_left = 0;

  track_observation_insert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // insert one observation into the predictor and return its result
  function automatic toi_pkg::toi_out_t insert_observation(input toi_pkg::toi_in_t obs);
    int unsigned       fill;
    int unsigned       base;
    int unsigned       hits;
    int unsigned       map_idx;
    bit                differ;
    toi_pkg::toi_out_t res;
    fill    = 32'(track_fill[obs.track]);
    base    = 32'(obs.track) * 32'(toi_pkg::MAX_PER_TRACK);
    map_idx = 32'({obs.camera, obs.feature});
    hits    = 0;
    differ  = 1'b0;
    // scan the stored observations of the track for this camera
    for (int i = 0; i < fill; i++) begin
      if (slot_ident[base+i][IDENT_W-1:toi_pkg::FEATURE_W] == obs.camera) begin
        if (slot_ident[base+i] != {obs.camera, obs.feature} ||
            slot_coords[base+i] != {obs.x_coord, obs.y_coord})
          differ = 1'b1;
        hits++;
      end
    end
    if (hits > 0) begin
      if (differ)
        res.status = toi_pkg::ST_CONFLICT;
      else if (hits > 1)
        res.status = toi_pkg::ST_DUPLICATE;
      else
        res.status = toi_pkg::ST_PRESENT;
    end else if (feature_taken[map_idx]) begin
      res.status = toi_pkg::ST_MAPPED;
    end else if (fill >= toi_pkg::MAX_PER_TRACK) begin
      res.status = toi_pkg::ST_FULL;
    end else begin
      slot_ident[base+fill]  = {obs.camera, obs.feature};
      slot_coords[base+fill] = {obs.x_coord, obs.y_coord};
      fill++;
      track_fill[obs.track]  = 5'(fill);
      feature_taken[map_idx] = 1'b1;
      res.status = toi_pkg::ST_ADDED;
    end
    res.track_count = fill[4:0];
    return res;
  endfunction

  // send one item, predict its result once taken, then maybe pause
  task automatic send_observation(input toi_pkg::toi_in_t obs);
    start   <= 1'b1;
    in_item <= obs;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(insert_observation(obs));
    recent_obs.push_back(obs);
    if (recent_obs.size() > 48) void'(recent_obs.pop_front());
    // bursts of back-to-back items with random gaps between them
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  // result checker, the receiver cannot stall
  always @(posedge clk) begin
    toi_pkg::toi_out_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: status %0d count %0d",
                   out_item.status, out_item.track_count);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.status !== exp_res.status ||
            out_item.track_count !== exp_res.track_count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected status %0d count %0d, got status %0d count %0d",
                     exp_res.status, exp_res.track_count,
                     out_item.status, out_item.track_count);
        end
      end
    end
  end

  // field extremes, present, conflict and mapped cases
  task automatic test_field_extremes();
    toi_pkg::toi_in_t obs;
    obs = '{camera: 6'd0, feature: 12'd0, x_coord: 24'sh7fffff,
            y_coord: 24'sh800000, track: 12'd0};
    send_observation(obs);
    send_observation('{camera: 6'd63, feature: 12'd4095, x_coord: 24'sh800000,
                       y_coord: 24'sh7fffff, track: 12'd4095});
    // exact repeat is already present
    send_observation(obs);
    // same camera with other coordinates or another feature
    obs.x_coord = 24'sh000001;
    send_observation(obs);
    obs.x_coord = 24'sh7fffff;
    obs.feature = 12'd1;
    send_observation(obs);
    // feature already mapped to another track
    send_observation('{camera: 6'd63, feature: 12'd4095, x_coord: 24'sh800000,
                       y_coord: 24'sh7fffff, track: 12'd0});
    send_observation('{camera: 6'd1, feature: 12'd0, x_coord: 24'sh000000,
                       y_coord: 24'shffffff, track: 12'd4095});
  endtask

  // fill one track, then overflow it and hit the map on a full track
  task automatic test_track_full();
    toi_pkg::toi_in_t obs;
    obs = '{camera: 6'd2, feature: 12'd7, x_coord: 24'sh012345,
            y_coord: 24'sh054321, track: 12'd100};
    for (int c = 2; c < 2 + toi_pkg::MAX_PER_TRACK; c++) begin
      obs.camera = 6'(c);
      send_observation(obs);
    end
    obs.camera = 6'd18;
    send_observation(obs);
    // map check wins over the full track
    send_observation('{camera: 6'd0, feature: 12'd0, x_coord: 24'sh000100,
                       y_coord: 24'sh000200, track: 12'd100});
  endtask

  // random traffic built mostly from earlier items so tracks fill up
  task automatic test_random_traffic();
    toi_pkg::toi_in_t obs;
    int               choice;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      choice = $urandom_range(0, 99);
      if (recent_obs.size() == 0 || choice < 35) begin
        // fresh observation, small track pool with the odd wide track
        obs.camera  = 6'($urandom);
        obs.feature = 12'($urandom);
        obs.x_coord = 24'($urandom);
        obs.y_coord = 24'($urandom);
        if ($urandom_range(0, 9) == 0)
          obs.track = 12'($urandom_range(0, toi_pkg::NUM_TRACKS - 1));
        else
          obs.track = 12'($urandom_range(0, 23));
      end else begin
        obs = recent_obs[$urandom_range(0, recent_obs.size() - 1)];
        if (choice < 60) begin
          // exact repeat
        end else if (choice < 75) begin
          if ($urandom_range(0, 1)) obs.x_coord = 24'($urandom);
          else obs.y_coord = 24'($urandom);
        end else if (choice < 85) begin
          obs.feature = 12'($urandom);
        end else if (choice < 95) begin
          obs.track = 12'($urandom_range(0, 23));
        end else begin
          obs.camera = 6'($urandom);
        end
      end
      send_observation(obs);
    end
  endtask

  // run
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_track_full();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("track_observation_insert verification clean");
    end else begin
      $display("track_observation_insert verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("track_observation_insert verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/toi_pkg.sv
hw/rtl/toi_entry_store.sv
hw/rtl/toi_track_table.sv
hw/rtl/track_observation_insert.sv
dv/testbench.sv
